// ----- rtl/bmg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bmg_pkg;

  localparam logic [30:0] TWO_LN2_Q30     = 31'd1488522236;
  localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;
  localparam logic [32:0] CORDIC_GAIN_Q30 = 33'd652032874;
  localparam logic [4:0]  CORDIC_LAST     = 5'd29;
  localparam logic [4:0]  LOG_LAST        = 5'd29;

  localparam logic        REG_MEAN     = 1'b0;
  localparam logic        REG_VARIANCE = 1'b1;

  localparam logic [31:0] MEAN_RESET     = 32'd0;
  localparam logic [31:0] VARIANCE_RESET = 32'd65536;

  typedef struct packed {
    logic load;
    logic prep;
    logic start_a;
    logic mul_r2;
    logic start_r;
    logic mul_z;
    logic mul_s;
    logic out_load;
  } bmg_cmd_t;

  typedef struct packed {
    logic a_done;
    logic r_done;
  } bmg_sts_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:    a = 32'd843314856;
      5'd1:    a = 32'd497837829;
      5'd2:    a = 32'd263043836;
      5'd3:    a = 32'd133525158;
      5'd4:    a = 32'd67021686;
      5'd5:    a = 32'd33543515;
      5'd6:    a = 32'd16775850;
      5'd7:    a = 32'd8388437;
      5'd8:    a = 32'd4194282;
      5'd9:    a = 32'd2097149;
      5'd10:   a = 32'd1048575;
      5'd11:   a = 32'd524287;
      5'd12:   a = 32'd262143;
      5'd13:   a = 32'd131071;
      5'd14:   a = 32'd65535;
      5'd15:   a = 32'd32767;
      5'd16:   a = 32'd16383;
      5'd17:   a = 32'd8191;
      5'd18:   a = 32'd4095;
      5'd19:   a = 32'd2047;
      5'd20:   a = 32'd1023;
      5'd21:   a = 32'd511;
      5'd22:   a = 32'd255;
      5'd23:   a = 32'd127;
      5'd24:   a = 32'd63;
      5'd25:   a = 32'd31;
      5'd26:   a = 32'd15;
      5'd27:   a = 32'd7;
      5'd28:   a = 32'd3;
      5'd29:   a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/box_muller_gaussian_sampler.sv -----
// Requests: one at a time; req_stall holds off a new request until the current
// sample is loaded for output. Each request makes two 32-step square-root passes
// on the shared iterative root unit (log and CORDIC run beside the first).
// Reset: synchronous, active high; clears phase, handshake and control state,
// and loads mean 0.0 and variance 1.0.
`timescale 1ns / 1ps
`default_nettype none
module box_muller_gaussian_sampler
  import bmg_pkg::*;
#(
  parameter int RAND_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [15:0] uniform_u_raw,
  input  wire logic [15:0] uniform_v_raw,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic      [31:0] gauss_sample,
  output logic             used_cosine
);

  bmg_cmd_t cmd;
  bmg_sts_t sts;

  bmg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bmg_datapath #(
    .RAND_BITS (RAND_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .uniform_u_raw (uniform_u_raw),
    .uniform_v_raw (uniform_v_raw),
    .cmd           (cmd),
    .sts           (sts),
    .gauss_sample  (gauss_sample),
    .used_cosine   (used_cosine)
  );

endmodule
`default_nettype wire

// ----- rtl/bmg_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bmg_isqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] operand,
  output logic      [31:0] root,
  output logic             busy
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitpos;
  logic [63:0] trial;

  assign trial = res + bitpos;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bitpos[0]) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= operand;
      res    <= '0;
      bitpos <= 64'd1 << 62;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitpos;
      end else begin
        res <= res >> 1;
      end
      bitpos <= bitpos >> 2;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bmg_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bmg_cordic
  import bmg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic        [30:0] angle,
  output logic signed      [32:0] x,
  output logic signed      [32:0] y,
  output logic                    busy
);

  logic        [4:0]  k;
  logic signed [32:0] z;
  logic signed [32:0] xs;
  logic signed [32:0] ys;
  logic signed [32:0] a;

  assign xs = x >>> k;
  assign ys = y >>> k;
  assign a  = $signed({1'b0, atan_q30(k)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && k == CORDIC_LAST) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= $signed(CORDIC_GAIN_Q30);
      y <= '0;
      z <= $signed({2'b00, angle});
      k <= '0;
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - a;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + a;
      end
      k <= k + 5'd1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bmg_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bmg_ctrl
  import bmg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  wire logic     rsp_stall,
  input  wire bmg_sts_t sts,
  output bmg_cmd_t      cmd
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_PREP    = 10'b0000000010,
    S_START_A = 10'b0000000100,
    S_WAIT_A  = 10'b0000001000,
    S_MUL_R2  = 10'b0000010000,
    S_START_R = 10'b0000100000,
    S_WAIT_R  = 10'b0001000000,
    S_MUL_Z   = 10'b0010000000,
    S_MUL_S   = 10'b0100000000,
    S_FINISH  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_START_A;
      end
      S_START_A: begin
        cmd.start_a = 1'b1;
        state_next  = S_WAIT_A;
      end
      S_WAIT_A: begin
        if (sts.a_done) state_next = S_MUL_R2;
      end
      S_MUL_R2: begin
        cmd.mul_r2 = 1'b1;
        state_next = S_START_R;
      end
      S_START_R: begin
        cmd.start_r = 1'b1;
        state_next  = S_WAIT_R;
      end
      S_WAIT_R: begin
        if (sts.r_done) state_next = S_MUL_Z;
      end
      S_MUL_Z: begin
        cmd.mul_z  = 1'b1;
        state_next = S_MUL_S;
      end
      S_MUL_S: begin
        cmd.mul_s  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bmg_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bmg_datapath
  import bmg_pkg::*;
#(
  parameter int RAND_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic        [31:0] cfg_data,
  input  wire logic        [15:0] uniform_u_raw,
  input  wire logic        [15:0] uniform_v_raw,
  input  wire bmg_cmd_t           cmd,
  output bmg_sts_t                sts,
  output logic             [31:0] gauss_sample,
  output logic                    used_cosine
);

  localparam int unsigned SH = 32 - RAND_BITS;
  localparam logic [15:0] RAW_MASK =
    (RAND_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << RAND_BITS) - 32'd1);

  logic        [31:0] mean_value;
  logic        [31:0] variance_value;
  logic               phase;
  logic               cos_sel;
  logic        [15:0] kept_u;
  logic        [15:0] kept_v;

  logic        [16:0] w_u;
  logic        [16:0] w_v;
  logic        [4:0]  msb_u;
  logic        [46:0] m_wide;
  logic        [63:0] t_wide;
  logic        [31:0] t_val;
  logic        [60:0] ang_prod;

  logic        [30:0] angle;
  logic        [1:0]  quad;
  logic        [5:0]  exp_q;
  logic        [30:0] m;
  logic        [29:0] f;
  logic        [4:0]  lcnt;
  logic               lbusy;
  logic        [61:0] sq;
  logic        [31:0] mp;

  logic        [35:0] l_val;
  logic        [63:0] lprod;
  logic        [36:0] r2;
  logic        [24:0] sd_q;

  logic        [63:0] isq_op;
  logic        [31:0] isq_root;
  logic               isq_busy;
  logic signed [32:0] cx;
  logic signed [32:0] cy;
  logic               cbusy;

  logic signed [32:0] trig;
  logic signed [65:0] zprod;
  logic signed [31:0] z;
  logic signed [57:0] sprod;
  logic signed [33:0] s_sh;
  logic signed [34:0] acc;
  logic        [31:0] sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_value     <= MEAN_RESET;
      variance_value <= VARIANCE_RESET;
      phase          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MEAN:     mean_value     <= cfg_data;
          REG_VARIANCE: variance_value <= cfg_data;
          default:      ;
        endcase
      end
      if (cmd.load) phase <= ~phase;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cos_sel <= phase;
      if (!phase) begin
        kept_u <= uniform_u_raw;
        kept_v <= uniform_v_raw;
      end
    end
  end

  always_comb begin
    w_u   = {1'b0, kept_u & RAW_MASK} + 17'd1;
    w_v   = {1'b0, kept_v & RAW_MASK} + 17'd1;
    msb_u = '0;
    for (int i = 0; i < 17; i++) begin
      if (w_u[i]) msb_u = 5'(i);
    end
    m_wide   = {30'b0, w_u} << (5'd30 - msb_u);
    t_wide   = {47'b0, w_v} << SH;
    t_val    = t_wide[31:0];
    ang_prod = 61'(t_val[29:0]) * 61'(HALF_PI_Q30);
  end

  assign sq = 62'(m) * 62'(m);
  assign mp = sq[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      lbusy <= 1'b0;
    end else if (cmd.start_a) begin
      lbusy <= 1'b1;
    end else if (lbusy && lcnt == '0) begin
      lbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      m     <= m_wide[30:0];
      exp_q <= 6'(RAND_BITS) - {1'b0, msb_u};
      angle <= ang_prod[60:30];
      quad  <= t_val[31:30];
      f     <= '0;
      lcnt  <= LOG_LAST;
    end else if (lbusy) begin
      if (mp[31]) begin
        m       <= mp[31:1];
        f[lcnt] <= 1'b1;
      end else begin
        m <= mp[30:0];
      end
      lcnt <= lcnt - 5'd1;
    end
  end

  assign l_val = {exp_q, 30'b0} - {6'b0, f};
  assign lprod = 64'(l_val[35:4]) * 64'(TWO_LN2_Q30);

  always_ff @(posedge clk) begin
    if (cmd.mul_r2) begin
      r2   <= lprod[62:26];
      sd_q <= isq_root[24:0];
    end
  end

  assign isq_op = cmd.start_r ? {1'b0, r2, 26'b0} : {16'b0, variance_value, 16'b0};

  bmg_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start_a | cmd.start_r),
    .operand (isq_op),
    .root    (isq_root),
    .busy    (isq_busy)
  );

  bmg_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_a),
    .angle (angle),
    .x     (cx),
    .y     (cy),
    .busy  (cbusy)
  );

  assign sts.a_done = !lbusy && !isq_busy && !cbusy;
  assign sts.r_done = !isq_busy;

  always_comb begin
    case ({cos_sel, quad})
      3'b000:  trig = cy;
      3'b001:  trig = cx;
      3'b010:  trig = -cy;
      3'b011:  trig = -cx;
      3'b100:  trig = cx;
      3'b101:  trig = -cy;
      3'b110:  trig = -cx;
      3'b111:  trig = cy;
      default: trig = cy;
    endcase
  end

  assign zprod = $signed({1'b0, isq_root}) * trig;
  assign sprod = z * $signed({1'b0, sd_q});

  always_ff @(posedge clk) begin
    if (cmd.mul_z) z <= zprod[65:34];
    if (cmd.mul_s) s_sh <= sprod[57:24];
  end

  always_comb begin
    acc = {{3{mean_value[31]}}, mean_value} + {s_sh[33], s_sh};
    if (acc[34] && acc[33:31] != 3'b111) begin
      sat = 32'h8000_0000;
    end else if (!acc[34] && acc[33:31] != 3'b000) begin
      sat = 32'h7FFF_FFFF;
    end else begin
      sat = acc[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      gauss_sample <= sat;
      used_cosine  <= cos_sel;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bmg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bmg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_stall,
  input wire logic        rsp_valid,
  input wire logic        rsp_stall,
  input wire logic [31:0] gauss_sample,
  input wire logic        used_cosine
);

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while not busy afterwards");

  a_rsp_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("sample appeared without a request in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(gauss_sample) && $stable(used_cosine))
    else $error("stalled sample beat changed");

endmodule

bind box_muller_gaussian_sampler bmg_checker u_bmg_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .gauss_sample (gauss_sample),
  .used_cosine  (used_cosine)
);
`default_nettype wire
